/* hw/rtl/cdq_pkg.sv */
package cdq_pkg;

  localparam int DATA_W      = 32;
  localparam int DEPTH_DFLT  = 128;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_t;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // item taken this cycle
    logic finish;  // store read data is back, complete the pop
  } cdq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic need_read;  // pending item is a pop that must refetch an end value
    logic out_free;   // result register empty or being taken
  } cdq_sts_t;

endpackage

/* hw/rtl/cdq_req_if.sv */
interface cdq_req_if
  import cdq_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  data_t       value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

/* hw/rtl/cdq_rsp_if.sv */
interface cdq_rsp_if
  import cdq_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  data_t       popped;
  data_t       front_value;
  data_t       rear_value;
  logic        is_empty;
  logic        is_full;

  modport source (output valid, output status, output popped, output front_value,
                  output rear_value, output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input popped, input front_value,
                  input rear_value, input is_empty, input is_full, output ready);
endinterface

/* hw/rtl/cdq_ram.sv */
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/cdq_ctrl.sv */
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cdq_sts_t sts,
  output logic     in_ready,
  output cdq_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state;

  assign in_ready   = (state == S_IDLE) && sts.out_free;
  assign cmd.accept = sts.in_valid && in_ready;
  assign cmd.finish = (state == S_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.accept && sts.need_read) begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/cdq_dp.sv */
module cdq_dp
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DFLT
) (
  input  logic       clk,
  input  logic       rst,
  input  cdq_cmd_t   cmd,
  output cdq_sts_t   sts,
  cdq_req_if.sink    req,
  cdq_rsp_if.source  rsp
);

  localparam int AW = $clog2(DEPTH);
  typedef logic [AW-1:0] ptr_t;

  function automatic ptr_t nxt(input ptr_t p);
    return (p == ptr_t'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t prv(input ptr_t p);
    return (p == '0) ? ptr_t'(DEPTH - 1) : p - 1'b1;
  endfunction

  ptr_t  front_ptr, front_ptr_next;
  ptr_t  rear_ptr, rear_ptr_next;
  logic  empty_mark, empty_mark_next;
  data_t front_val, front_val_next;
  data_t rear_val, rear_val_next;
  logic  pend_front, pend_front_next;
  data_t pend_popped, pend_popped_next;

  logic       out_valid;
  logic [1:0] out_status;
  data_t      out_popped, out_front, out_rear;
  logic       out_empty, out_full;

  logic       ld;
  logic [1:0] ld_status;
  data_t      ld_popped;
  logic       full_now;
  logic       ram_we, ram_re;
  ptr_t       ram_waddr, ram_raddr;
  data_t      ram_rdata;
  action_t    act;

  assign act      = action_t'(req.action);
  assign full_now = !empty_mark && (nxt(rear_ptr) == front_ptr);

  assign sts.in_valid  = req.valid;
  assign sts.need_read = req.action[1] && !empty_mark && (front_ptr != rear_ptr);
  assign sts.out_free  = !out_valid || rsp.ready;

  always_comb begin
    front_ptr_next   = front_ptr;
    rear_ptr_next    = rear_ptr;
    empty_mark_next  = empty_mark;
    front_val_next   = front_val;
    rear_val_next    = rear_val;
    pend_front_next  = pend_front;
    pend_popped_next = pend_popped;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_re           = 1'b0;
    ram_raddr        = '0;
    ld               = 1'b0;
    ld_status        = ST_DONE;
    ld_popped        = '0;

    if (cmd.accept) begin
      ld = 1'b1;
      case (act)
        ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
          if (full_now) begin
            ld_status = ST_OVERFLOW;
          end else if (empty_mark) begin
            front_ptr_next  = '0;
            rear_ptr_next   = '0;
            empty_mark_next = 1'b0;
            front_val_next  = req.value;
            rear_val_next   = req.value;
            ram_we          = 1'b1;
          end else if (act == ACT_PUSH_FRONT) begin
            front_ptr_next = prv(front_ptr);
            front_val_next = req.value;
            ram_we         = 1'b1;
            ram_waddr      = prv(front_ptr);
          end else begin
            rear_ptr_next = nxt(rear_ptr);
            rear_val_next = req.value;
            ram_we        = 1'b1;
            ram_waddr     = nxt(rear_ptr);
          end
        end
        ACT_POP_FRONT, ACT_POP_REAR: begin
          if (empty_mark) begin
            ld_status = ST_EMPTY;
          end else begin
            ld_popped        = (act == ACT_POP_FRONT) ? front_val : rear_val;
            pend_popped_next = ld_popped;
            pend_front_next  = (act == ACT_POP_FRONT);
            if (front_ptr == rear_ptr) begin
              // last item gone: back to empty
              empty_mark_next = 1'b1;
              front_ptr_next  = '0;
              rear_ptr_next   = '0;
              front_val_next  = '0;
              rear_val_next   = '0;
            end else begin
              // fetch the new end value; the result is registered when the read data is back
              ld     = 1'b0;
              ram_re = 1'b1;
              if (act == ACT_POP_FRONT) begin
                front_ptr_next = nxt(front_ptr);
                ram_raddr      = nxt(front_ptr);
              end else begin
                rear_ptr_next = prv(rear_ptr);
                ram_raddr     = prv(rear_ptr);
              end
            end
          end
        end
        default: ld_status = ST_DONE;
      endcase
    end else if (cmd.finish) begin
      ld        = 1'b1;
      ld_popped = pend_popped;
      if (pend_front) begin
        front_val_next = ram_rdata;
      end else begin
        rear_val_next = ram_rdata;
      end
    end
  end

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front_ptr  <= '0;
      rear_ptr   <= '0;
      empty_mark <= 1'b1;
      front_val  <= '0;
      rear_val   <= '0;
      out_valid  <= 1'b0;
    end else begin
      front_ptr  <= front_ptr_next;
      rear_ptr   <= rear_ptr_next;
      empty_mark <= empty_mark_next;
      front_val  <= front_val_next;
      rear_val   <= rear_val_next;
      if (ld) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_front  <= pend_front_next;
    pend_popped <= pend_popped_next;
    if (ld) begin
      out_status <= ld_status;
      out_popped <= ld_popped;
      out_front  <= empty_mark_next ? '0 : front_val_next;
      out_rear   <= empty_mark_next ? '0 : rear_val_next;
      out_empty  <= empty_mark_next;
      out_full   <= !empty_mark_next && (nxt(rear_ptr_next) == front_ptr_next);
    end
  end

  assign req.ready       = !cmd.finish && sts.out_free;
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.popped      = out_popped;
  assign rsp.front_value = out_front;
  assign rsp.rear_value  = out_rear;
  assign rsp.is_empty    = out_empty;
  assign rsp.is_full     = out_full;

endmodule

/* hw/rtl/circular_deque.sv */
// Results: a push, a failed request or a pop of the last item has its result
// registered straight from the request; any other pop first fetches the new
// end through the store's single registered read port. Requests are taken one
// per cycle while the result register is free, but none during such a fetch.
// Reset: both pointers go to zero and the deque reads empty; the store is not
// cleared and needs no clearing pass.
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DFLT
) (
  input  logic       clk,
  input  logic       rst,
  cdq_req_if.sink    req,
  cdq_rsp_if.source  rsp
);

  cdq_cmd_t cmd;
  cdq_sts_t sts;
  logic     ctrl_ready;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sts      (sts),
    .in_ready (ctrl_ready),
    .cmd      (cmd)
  );

  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp)
  );

  // a pop completion always follows the accept of that pop
  assert property (@(posedge clk) disable iff (rst) cmd.finish |-> $past(cmd.accept))
    else $error("pop completion without a preceding accept");

  // controller and datapath agree on when an item may enter
  assert property (@(posedge clk) disable iff (rst) ctrl_ready == req.ready)
    else $error("ready mismatch between controller and datapath");

  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.is_empty && rsp.is_full))
    else $error("result reports both empty and full");

  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_DONE) |-> (rsp.popped == '0))
    else $error("failed request returned a popped value");

endmodule

/* sim/circular_deque_tb.sv */
`timescale 1ns / 1ps

module circular_deque_tb;
  import cdq_pkg::*;

  localparam int DEPTH = DEPTH_DFLT;
  localparam int N_ITEMS = 1400;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam longint LIMIT_CYCLES = 600000;

  typedef struct {
    action_t action;
    data_t   value;
  } dq_req_t;

  typedef struct {
    logic [1:0] status;
    data_t      popped;
    data_t      front_value;
    data_t      rear_value;
    logic       is_empty;
    logic       is_full;
  } dq_result_t;

  logic clk = 1'b0;
  logic rst;

  cdq_req_if req_ch ();
  cdq_rsp_if rsp_ch ();

  circular_deque u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // shadow deque
  data_t       words [DEPTH];
  int unsigned head_idx;
  int unsigned tail_idx;
  bit          holds_none;

  dq_req_t     pending_q [$];
  dq_result_t  expected_q [$];

  int n_errors;
  int n_accepted;
  int n_results;
  int n_overflow;
  int n_underflow;
  int n_full_seen;
  int gen_level;

  bit req_took;
  int send_gap;
  int send_calm;
  int stall_left;
  int recv_calm;
  int hold_left;
  int holds_done;

  function automatic bit at_capacity();
    return !holds_none && ((tail_idx + 1) % DEPTH) == head_idx;
  endfunction

  function automatic dq_result_t step_deque(action_t act, data_t val);
    dq_result_t r;
    r.status = ST_DONE;
    r.popped = '0;
    if (act == ACT_PUSH_FRONT || act == ACT_PUSH_REAR) begin
      if (at_capacity()) begin
        r.status = ST_OVERFLOW;
      end else if (holds_none) begin
        // first item lands in entry zero whichever end it came from
        head_idx = 0;
        tail_idx = 0;
        words[0] = val;
        holds_none = 1'b0;
      end else if (act == ACT_PUSH_FRONT) begin
        head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
        words[head_idx] = val;
      end else begin
        tail_idx = (tail_idx + 1 == DEPTH) ? 0 : tail_idx + 1;
        words[tail_idx] = val;
      end
    end else if (holds_none) begin
      r.status = ST_EMPTY;
    end else begin
      r.popped = (act == ACT_POP_FRONT) ? words[head_idx] : words[tail_idx];
      if (head_idx == tail_idx) begin
        holds_none = 1'b1;
        head_idx = 0;
        tail_idx = 0;
      end else if (act == ACT_POP_FRONT) begin
        head_idx = (head_idx + 1 == DEPTH) ? 0 : head_idx + 1;
      end else begin
        tail_idx = (tail_idx == 0) ? DEPTH - 1 : tail_idx - 1;
      end
    end
    r.front_value = holds_none ? '0 : words[head_idx];
    r.rear_value  = holds_none ? '0 : words[tail_idx];
    r.is_empty    = holds_none;
    r.is_full     = at_capacity();
    return r;
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, want, got);
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic data_t rand_word();
    case ($urandom_range(0, 15))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(action_t act, data_t val);
    dq_req_t it;
    it.action = act;
    it.value = val;
    pending_q.push_back(it);
    if (act == ACT_PUSH_FRONT || act == ACT_PUSH_REAR) begin
      if (gen_level < DEPTH) gen_level++;
    end else if (gen_level > 0) begin
      gen_level--;
    end
  endtask

  task automatic build_stimulus();
    int n;
    int kind;
    bit first;
    // empty pops, single-item round trips at both ends, extreme words
    add_item(ACT_POP_FRONT, 32'sh1234_5678);
    add_item(ACT_POP_REAR, '1);
    add_item(ACT_PUSH_FRONT, 32'sh8000_0000);
    add_item(ACT_POP_FRONT, '0);
    add_item(ACT_PUSH_REAR, 32'sh7FFF_FFFF);
    add_item(ACT_POP_REAR, '0);
    add_item(ACT_PUSH_REAR, '0);
    add_item(ACT_PUSH_FRONT, '1);
    add_item(ACT_PUSH_REAR, 32'sh5555_5555);
    add_item(ACT_PUSH_FRONT, 32'shAAAA_AAAA);
    add_item(ACT_POP_FRONT, '0);
    add_item(ACT_POP_REAR, '0);
    add_item(ACT_POP_REAR, '0);
    add_item(ACT_POP_FRONT, '0);
    add_item(ACT_POP_FRONT, '0);
    // front wraps below entry zero, then unwinds from the rear; then two rear pushes popped from the front
    add_item(ACT_PUSH_FRONT, 32'sd1);
    add_item(ACT_PUSH_FRONT, 32'sd2);
    add_item(ACT_POP_REAR, '0);
    add_item(ACT_POP_REAR, '0);
    add_item(ACT_PUSH_REAR, 32'sd3);
    add_item(ACT_PUSH_REAR, 32'sd4);
    add_item(ACT_POP_FRONT, '0);
    add_item(ACT_POP_FRONT, '0);

    first = 1'b1;
    while (pending_q.size() < N_ITEMS) begin
      kind = first ? 0 : $urandom_range(0, 9);
      first = 1'b0;
      case (kind)
        0, 1: begin
          // run past full so some pushes overflow
          n = DEPTH - gen_level + $urandom_range(1, 4);
          repeat (n) add_item($urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT,
                              rand_word());
        end
        2, 3: begin
          n = gen_level + $urandom_range(1, 3);
          repeat (n) add_item($urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT,
                              rand_word());
        end
        default: begin
          n = $urandom_range(8, 40);
          repeat (n) add_item(action_t'($urandom_range(0, 3)), rand_word());
        end
      endcase
    end
  endtask

  // sender
  always @(negedge clk) begin : drive_req
    dq_req_t cur;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_took) begin
      // hold the item until it is taken
    end else if (send_gap != 0) begin
      req_ch.valid <= 1'b0;
      send_gap = send_gap - 1;
    end else if (pending_q.size() != 0) begin
      cur = pending_q.pop_front();
      req_ch.valid <= 1'b1;
      req_ch.action <= cur.action;
      req_ch.value <= cur.value;
      if (send_calm != 0) begin
        send_calm = send_calm - 1;
        send_gap = 0;
      end else begin
        send_gap = pick_gap();
        if ($urandom_range(0, 59) == 0) send_calm = 60;
      end
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // receiver, with long hold-offs so the deque backs up into its input
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (holds_done < 2 && n_results >= (holds_done == 0 ? 250 : 800)) begin
      rsp_ch.ready <= 1'b0;
      hold_left = LONG_HOLD;
      holds_done++;
    end else if (stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (recv_calm != 0) begin
        recv_calm = recv_calm - 1;
      end else begin
        stall_left = pick_gap();
        if ($urandom_range(0, 59) == 0) recv_calm = 60;
      end
    end
  end

  // check results, then predict for the item taken at this edge
  always @(posedge clk) begin : observe
    dq_result_t want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_results++;
        if (rsp_ch.status === ST_OVERFLOW) n_overflow++;
        if (rsp_ch.status === ST_EMPTY) n_underflow++;
        if (rsp_ch.is_full === 1'b1) n_full_seen++;
        if (expected_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result: expected none, got status %0h popped %0h",
                   $time, rsp_ch.status, rsp_ch.popped);
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, rsp_ch.status);
          check_field("popped", want.popped, rsp_ch.popped);
          check_field("front_value", want.front_value, rsp_ch.front_value);
          check_field("rear_value", want.rear_value, rsp_ch.rear_value);
          check_field("is_empty", want.is_empty, rsp_ch.is_empty);
          check_field("is_full", want.is_full, rsp_ch.is_full);
        end
      end
      req_took = req_ch.valid && req_ch.ready;
      if (req_took) begin
        n_accepted++;
        expected_q.push_back(step_deque(action_t'(req_ch.action), req_ch.value));
      end
    end else begin
      req_took = 1'b0;
    end
  end

  initial begin
    int total;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_PUSH_FRONT;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    head_idx = 0;
    tail_idx = 0;
    holds_none = 1'b1;
    build_stimulus();
    total = pending_q.size();
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    wait (n_accepted == total);
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests through the deque: %0d overflowed pushes, %0d pops on empty,",
             n_accepted, n_overflow, n_underflow);
    $display("%0d results reported full, %0d long receiver hold-offs, %0d mismatches.",
             n_full_seen, holds_done, n_errors);
    if (n_errors == 0) begin
      $display("circular_deque regression: pass");
    end else begin
      $display("circular_deque regression: fail");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("Timeout after %0d cycles with %0d results outstanding.",
             LIMIT_CYCLES, expected_q.size());
    $display("circular_deque regression: fail");
    $finish;
  end

endmodule
